// ===== hw/rtl/three_level_strict_priority_queue_macros.svh =====
// Assertion macros for the three-level strict priority queue.
// Included by the top level; depends on nothing else.
`ifndef THREE_LEVEL_STRICT_PRIORITY_QUEUE_MACROS_SVH
`define THREE_LEVEL_STRICT_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define TLSPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define TLSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TLSPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TLSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tlspq_pkg.sv =====
// Shared constants, codes and controller/datapath types of the priority queue.
// Depends on nothing; used by every RTL file but the RAM and the macros.
`default_nettype none
package tlspq_pkg;

    // Sizing of the rings.
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_W       = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CLASS_COUNT = 3;
    localparam int IDX_W       = 2;

    // Field widths of the request and response.
    localparam int FUNC_W   = 1;
    localparam int CLS_W    = 3;
    localparam int ROOM_W   = 8;
    localparam int STATUS_W = 3;
    localparam int SCLS_W   = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SERVE   = 1'b1;

    // Class codes of an enqueue request.
    localparam logic [CLS_W-1:0] CLS_NORMAL = 3'd1;
    localparam logic [CLS_W-1:0] CLS_URGENT = 3'd3;

    // Ring indices.
    localparam logic [IDX_W-1:0] IDX_NORMAL   = 2'd0;
    localparam logic [IDX_W-1:0] IDX_PRIORITY = 2'd1;
    localparam logic [IDX_W-1:0] IDX_URGENT   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED = 3'd0,
        ST_SERVED   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_INVALID  = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // a request is taken this cycle
        logic load_now;   // result is known now, load the output register
        logic load_read;  // load the output register from the ring read data
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic serve_hit;  // a serve request would find a stored tag
    } t_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/tlspq_req_if.sv =====
// Request channel of the priority queue: valid/ready handshake and payload.
// Depends on tlspq_pkg for field widths.
`default_nettype none
interface tlspq_req_if;
    logic                           valid;
    logic                           ready;
    logic [tlspq_pkg::FUNC_W-1:0]   func;
    logic [tlspq_pkg::CLS_W-1:0]    priority_class;
    logic [tlspq_pkg::TAG_W-1:0]    record_tag;
    logic [tlspq_pkg::ROOM_W-1:0]   room_number;

    modport source (output valid, func, priority_class, record_tag, room_number,
                    input ready);
    modport sink   (input valid, func, priority_class, record_tag, room_number,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tlspq_rsp_if.sv =====
// Response channel of the priority queue: valid/ready handshake and payload.
// Depends on tlspq_pkg for field widths.
`default_nettype none
interface tlspq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [tlspq_pkg::STATUS_W-1:0]  status;
    logic [tlspq_pkg::TAG_W-1:0]     served_tag;
    logic [tlspq_pkg::SCLS_W-1:0]    served_class;
    logic [tlspq_pkg::ROOM_W-1:0]    served_room;

    modport source (output valid, status, served_tag, served_class, served_room,
                    input ready);
    modport sink   (input valid, status, served_tag, served_class, served_room,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tlspq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module tlspq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic                                   i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tlspq_ctrl.sv =====
// Controller of the priority queue: handshake, state machine and output valid.
// Depends on tlspq_pkg.
`default_nettype none
module tlspq_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    input  wire logic [tlspq_pkg::FUNC_W-1:0]  i_req_func,
    input  wire logic                          i_rsp_ready,
    input  wire tlspq_pkg::t_sts               i_sts,
    output logic                               o_req_ready,
    output logic                               o_rsp_valid,
    output tlspq_pkg::t_cmd                    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;
    logic   accept;
    logic   serve_hit;

    // The output register can take a result when it is empty or being emptied.
    assign slot_free   = !r_out_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE) && slot_free;
    assign accept      = i_req_valid && o_req_ready;
    assign serve_hit   = accept && (i_req_func == tlspq_pkg::FUNC_SERVE) && i_sts.serve_hit;

    // Commands to the datapath.
    always_comb begin
        o_cmd.accept    = accept;
        o_cmd.load_now  = accept && !serve_hit;
        o_cmd.load_read = (r_state == S_READ);
    end

    // Next state: a serve that finds a tag moves to S_READ for the ring read, then back to S_IDLE.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (serve_hit) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid is set on a load and cleared when the sink takes the result.
    always_comb begin
        if (o_cmd.load_now || o_cmd.load_read) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/tlspq_dp.sv =====
// Datapath of the priority queue: ring pointers, counts, tag RAMs and result register.
// Depends on tlspq_pkg and tlspq_ram.
`default_nettype none
module tlspq_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tlspq_pkg::t_cmd                 i_cmd,
    input  wire logic [tlspq_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [tlspq_pkg::CLS_W-1:0]     i_priority_class,
    input  wire logic [tlspq_pkg::TAG_W-1:0]     i_record_tag,
    input  wire logic [tlspq_pkg::ROOM_W-1:0]    i_room_number,
    output tlspq_pkg::t_sts                      o_sts,
    output logic      [tlspq_pkg::STATUS_W-1:0]  o_status,
    output logic      [tlspq_pkg::TAG_W-1:0]     o_served_tag,
    output logic      [tlspq_pkg::SCLS_W-1:0]    o_served_class,
    output logic      [tlspq_pkg::ROOM_W-1:0]    o_served_room
);

    localparam int PW = tlspq_pkg::PTR_W;
    localparam int CW = tlspq_pkg::CNT_W;
    localparam int IW = tlspq_pkg::IDX_W;
    localparam int NC = tlspq_pkg::CLASS_COUNT;

    logic [PW-1:0] r_head [NC];
    logic [PW-1:0] r_tail [NC];
    logic [CW-1:0] r_count [NC];

    // Held across the ring read of a serve.
    logic [IW-1:0]                  r_sel;
    logic [tlspq_pkg::ROOM_W-1:0]   r_room;

    // Result register.
    logic [tlspq_pkg::STATUS_W-1:0] r_status;
    logic [tlspq_pkg::TAG_W-1:0]    r_tag;
    logic [tlspq_pkg::SCLS_W-1:0]   r_class;
    logic [tlspq_pkg::ROOM_W-1:0]   r_room_out;

    logic          is_serve;
    logic          cls_ok;
    logic [IW-1:0] enq_idx;
    logic          enq_full;
    logic          do_enq;
    logic [IW-1:0] sel_idx;
    logic          any_held;
    logic          do_pop;
    logic [NC-1:0] wr_en;
    logic [NC-1:0] rd_en;
    logic [tlspq_pkg::TAG_W-1:0] rd_data [NC];
    logic [tlspq_pkg::STATUS_W-1:0] now_status;

    // Class code of a ring index: normal is 1, urgent is 3.
    function automatic logic [tlspq_pkg::SCLS_W-1:0] SCLS_CLASS(input logic [IW-1:0] idx);
        return tlspq_pkg::SCLS_W'(idx) + 1'b1;
    endfunction

    // Decode the enqueue class and check the ring for room.
    assign is_serve = (i_func == tlspq_pkg::FUNC_SERVE);
    assign cls_ok   = (i_priority_class >= tlspq_pkg::CLS_NORMAL)
                   && (i_priority_class <= tlspq_pkg::CLS_URGENT);
    assign enq_idx  = IW'(i_priority_class - tlspq_pkg::CLS_NORMAL);
    assign enq_full = cls_ok && (r_count[enq_idx] == CW'(tlspq_pkg::QUEUE_DEPTH));
    assign do_enq   = i_cmd.accept && !is_serve && cls_ok && !enq_full;

    // Strict priority pick: urgent, then priority, then normal.
    always_comb begin
        any_held = 1'b1;
        if (r_count[tlspq_pkg::IDX_URGENT] != '0) begin
            sel_idx = tlspq_pkg::IDX_URGENT;
        end else if (r_count[tlspq_pkg::IDX_PRIORITY] != '0) begin
            sel_idx = tlspq_pkg::IDX_PRIORITY;
        end else begin
            sel_idx  = tlspq_pkg::IDX_NORMAL;
            any_held = (r_count[tlspq_pkg::IDX_NORMAL] != '0);
        end
    end

    assign o_sts.serve_hit = any_held;
    assign do_pop          = i_cmd.accept && is_serve && any_held;

    // Pointers and counts of the three rings.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NC; k++) begin
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            if (do_enq) begin
                r_tail[enq_idx]  <= (r_tail[enq_idx] == PW'(tlspq_pkg::QUEUE_DEPTH - 1))
                                    ? '0 : r_tail[enq_idx] + 1'b1;
                r_count[enq_idx] <= r_count[enq_idx] + 1'b1;
            end
            if (do_pop) begin
                r_head[sel_idx]  <= (r_head[sel_idx] == PW'(tlspq_pkg::QUEUE_DEPTH - 1))
                                    ? '0 : r_head[sel_idx] + 1'b1;
                r_count[sel_idx] <= r_count[sel_idx] - 1'b1;
            end
        end
    end

    // Remember which ring was read and the room to echo.
    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_sel  <= sel_idx;
            r_room <= i_room_number;
        end
    end

    // One tag RAM per class.
    for (genvar g = 0; g < NC; g++) begin : g_ring
        assign wr_en[g] = do_enq && (enq_idx == IW'(g));
        assign rd_en[g] = do_pop && (sel_idx == IW'(g));

        tlspq_ram #(
            .WIDTH (tlspq_pkg::TAG_W),
            .DEPTH (tlspq_pkg::QUEUE_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en[g]),
            .i_wr_addr (r_tail[g]),
            .i_wr_data (i_record_tag),
            .i_rd_en   (rd_en[g]),
            .i_rd_addr (r_head[g]),
            .o_rd_data (rd_data[g])
        );
    end

    // Status of a result that needs no ring read.
    always_comb begin
        if (is_serve) begin
            now_status = tlspq_pkg::ST_EMPTY;
        end else if (!cls_ok) begin
            now_status = tlspq_pkg::ST_INVALID;
        end else if (enq_full) begin
            now_status = tlspq_pkg::ST_FULL;
        end else begin
            now_status = tlspq_pkg::ST_ENQUEUED;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_now) begin
            r_status   <= now_status;
            r_tag      <= '0;
            r_class    <= '0;
            r_room_out <= '0;
        end else if (i_cmd.load_read) begin
            r_status   <= tlspq_pkg::ST_SERVED;
            r_tag      <= rd_data[r_sel];
            r_class    <= SCLS_CLASS(r_sel);
            r_room_out <= r_room;
        end
    end

    assign o_status       = r_status;
    assign o_served_tag   = r_tag;
    assign o_served_class = r_class;
    assign o_served_room  = r_room_out;

endmodule
`default_nettype wire

// ===== hw/rtl/three_level_strict_priority_queue.sv =====
// Three-level strict priority queue: a request channel in, one response per request out.
// It uses the requests i_req (enqueue or serve) and answers on o_rsp, valid/ready each.
// The block holds three rings of QUEUE_DEPTH tags, for the normal, priority and urgent class.
// An enqueue stores the tag at the tail of its class ring, or answers full or invalid class.
// A serve pops the oldest tag of the highest class that holds one, or answers all empty.
// An enqueue, a rejected enqueue or an empty serve answers on the cycle after acceptance;
// a serve that pops a tag answers only after the S_READ state, because the tag RAM has a
// registered read.
// Throughput: one request per cycle while results are taken; after a serve that pops a tag
// the block takes no new request while the controller is in S_READ for the RAM read.
// Reset clears all pointers and counts; the tag RAMs are not cleared, as
// only written entries are ever read. No clearing pass is needed.
// When the receiver stalls, the result waits in the output register and a new request
// is taken only in the cycle that register is emptied.
// Depends on tlspq_pkg, tlspq_req_if, tlspq_rsp_if, tlspq_ctrl, tlspq_dp and the macros.
`default_nettype none
`include "three_level_strict_priority_queue_macros.svh"
module three_level_strict_priority_queue (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tlspq_req_if.sink   i_req,
    tlspq_rsp_if.source o_rsp
);

    tlspq_pkg::t_cmd cmd;
    tlspq_pkg::t_sts sts;

    // Controller: handshake and sequencing.
    tlspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    // Datapath: rings and result register.
    tlspq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_func           (i_req.func),
        .i_priority_class (i_req.priority_class),
        .i_record_tag     (i_req.record_tag),
        .i_room_number    (i_req.room_number),
        .o_sts            (sts),
        .o_status         (o_rsp.status),
        .o_served_tag     (o_rsp.served_tag),
        .o_served_class   (o_rsp.served_class),
        .o_served_room    (o_rsp.served_room)
    );

    // A request is never taken while a stalled result still occupies the output.
    `TLSPQ_ASSERT_SAME(a_no_overrun, i_clk, i_rst_n, cmd.accept, !o_rsp.valid || o_rsp.ready, "request taken over a stalled result")

    // A serve that pops a tag blocks the next cycle while the RAM is read.
    `TLSPQ_ASSERT_NEXT(a_pop_blocks, i_clk, i_rst_n, cmd.accept && (i_req.func == tlspq_pkg::FUNC_SERVE) && sts.serve_hit, !i_req.ready && !o_rsp.valid, "pop did not wait for ring read")

    // An enqueue always answers in the next cycle.
    `TLSPQ_ASSERT_NEXT(a_enq_answer, i_clk, i_rst_n, cmd.accept && (i_req.func == tlspq_pkg::FUNC_ENQUEUE), o_rsp.valid, "enqueue result missing")

    // A served result always names a class.
    `TLSPQ_ASSERT_SAME(a_served_class, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status == tlspq_pkg::ST_SERVED), o_rsp.served_class != '0, "served result without class")

endmodule
`default_nettype wire

// ===== tb/three_level_strict_priority_queue_test.sv =====
// Self-checking test of the three-level strict priority queue: a stimulus table, then
// bursts of random enqueue and serve requests, each answer checked against a predictor or a typed answer.
// Depends on tlspq_pkg, the request and response interfaces and the top level of the RTL.
`timescale 1ns / 1ps
module three_level_strict_priority_queue_test;

    // Class codes that the package does not name.
    localparam logic [tlspq_pkg::CLS_W-1:0] CLS_NONE     = 3'd0;
    localparam logic [tlspq_pkg::CLS_W-1:0] CLS_PRIORITY = 3'd2;
    localparam logic [tlspq_pkg::CLS_W-1:0] CLS_HIGHEST  = 3'd7;

    localparam int RANDOM_PER_PHASE = 200;
    localparam int SETTLE_CYCLES    = 8;
    localparam int PRINT_LIMIT      = 40;

    typedef struct {
        tlspq_pkg::t_status                 status;
        logic [tlspq_pkg::TAG_W-1:0]        tag;
        logic [tlspq_pkg::SCLS_W-1:0]       cls;
        logic [tlspq_pkg::ROOM_W-1:0]       room;
    } t_answer;

    typedef struct {
        bit      known;
        t_answer ans;
    } t_typed_answer;

    typedef struct {
        int                                 reps;
        logic [tlspq_pkg::FUNC_W-1:0]       func;
        logic [tlspq_pkg::CLS_W-1:0]        cls;
        logic [tlspq_pkg::TAG_W-1:0]        tag;
        logic [tlspq_pkg::ROOM_W-1:0]       room;
        bit                                 known;
        t_answer                            ans;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tlspq_req_if req_if();
    tlspq_rsp_if rsp_if();

    three_level_strict_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Directed requests. Rows with a typed answer are checked against it directly.
    t_plan_row plan [9] = '{
        '{1, tlspq_pkg::FUNC_SERVE, CLS_NONE, 16'h0000, 8'hff, 1'b1,
          '{tlspq_pkg::ST_EMPTY, 16'h0000, 2'd0, 8'h00}},
        '{1, tlspq_pkg::FUNC_ENQUEUE, CLS_NONE, 16'hffff, 8'hff, 1'b1,
          '{tlspq_pkg::ST_INVALID, 16'h0000, 2'd0, 8'h00}},
        '{1, tlspq_pkg::FUNC_ENQUEUE, CLS_HIGHEST, 16'h1234, 8'h00, 1'b1,
          '{tlspq_pkg::ST_INVALID, 16'h0000, 2'd0, 8'h00}},
        '{1, tlspq_pkg::FUNC_ENQUEUE, tlspq_pkg::CLS_NORMAL, 16'h0000, 8'hff, 1'b1,
          '{tlspq_pkg::ST_ENQUEUED, 16'h0000, 2'd0, 8'h00}},
        '{1, tlspq_pkg::FUNC_ENQUEUE, CLS_PRIORITY, 16'hffff, 8'h5a, 1'b1,
          '{tlspq_pkg::ST_ENQUEUED, 16'h0000, 2'd0, 8'h00}},
        '{tlspq_pkg::QUEUE_DEPTH, tlspq_pkg::FUNC_ENQUEUE, tlspq_pkg::CLS_URGENT,
          16'h8000, 8'ha5, 1'b0,
          '{tlspq_pkg::ST_ENQUEUED, 16'h0000, 2'd0, 8'h00}},
        '{1, tlspq_pkg::FUNC_ENQUEUE, tlspq_pkg::CLS_URGENT, 16'h7fff, 8'h00, 1'b1,
          '{tlspq_pkg::ST_FULL, 16'h0000, 2'd0, 8'h00}},
        '{1, tlspq_pkg::FUNC_SERVE, CLS_HIGHEST, 16'hffff, 8'hff, 1'b0,
          '{tlspq_pkg::ST_SERVED, 16'h0000, 2'd0, 8'h00}},
        '{1, tlspq_pkg::FUNC_SERVE, CLS_NONE, 16'h0000, 8'h00, 1'b0,
          '{tlspq_pkg::ST_SERVED, 16'h0000, 2'd0, 8'h00}}
    };

    // Predictor state: one ring of tags per class, index 0 normal up to 2 urgent.
    logic [tlspq_pkg::TAG_W-1:0] tag_ring [tlspq_pkg::CLASS_COUNT][tlspq_pkg::QUEUE_DEPTH];
    int ring_head [tlspq_pkg::CLASS_COUNT];
    int ring_tail [tlspq_pkg::CLASS_COUNT];
    int ring_fill [tlspq_pkg::CLASS_COUNT];

    t_answer       awaited_answers [$];
    t_typed_answer typed_answers [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int answers_seen [5];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Works out the answer to one request and updates the rings.
    function automatic t_answer apply_request(logic [tlspq_pkg::FUNC_W-1:0] func,
                                              logic [tlspq_pkg::CLS_W-1:0] cls,
                                              logic [tlspq_pkg::TAG_W-1:0] tag,
                                              logic [tlspq_pkg::ROOM_W-1:0] room);
        t_answer a;
        int      idx;
        a.status = tlspq_pkg::ST_ENQUEUED;
        a.tag    = '0;
        a.cls    = '0;
        a.room   = '0;
        if (func == tlspq_pkg::FUNC_ENQUEUE) begin
            if (cls < tlspq_pkg::CLS_NORMAL || cls > tlspq_pkg::CLS_URGENT) begin
                a.status = tlspq_pkg::ST_INVALID;
            end else begin
                idx = int'(cls - tlspq_pkg::CLS_NORMAL);
                if (ring_fill[idx] >= tlspq_pkg::QUEUE_DEPTH) begin
                    a.status = tlspq_pkg::ST_FULL;
                end else begin
                    tag_ring[idx][ring_tail[idx]] = tag;
                    ring_tail[idx] = (ring_tail[idx] + 1) % tlspq_pkg::QUEUE_DEPTH;
                    ring_fill[idx]++;
                end
            end
        end else begin
            // The highest class that holds a tag is served first.
            idx = -1;
            for (int k = tlspq_pkg::CLASS_COUNT - 1; k >= 0; k--) begin
                if (idx < 0 && ring_fill[k] != 0) idx = k;
            end
            if (idx < 0) begin
                a.status = tlspq_pkg::ST_EMPTY;
            end else begin
                a.status = tlspq_pkg::ST_SERVED;
                a.tag    = tag_ring[idx][ring_head[idx]];
                a.cls    = tlspq_pkg::SCLS_W'(idx + 1);
                a.room   = room;
                ring_head[idx] = (ring_head[idx] + 1) % tlspq_pkg::QUEUE_DEPTH;
                ring_fill[idx]--;
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Responses are checked against the oldest expectation; accepted requests are predicted.
    always @(posedge i_clk) begin : check_block
        t_answer       want;
        t_answer       predicted;
        t_typed_answer typed;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited_answers.size() == 0) begin
                report_mismatch("unexpected response status", rsp_if.status, 0);
            end else begin
                want = awaited_answers.pop_front();
                if (rsp_if.status != want.status)
                    report_mismatch("status", rsp_if.status, want.status);
                if (rsp_if.served_tag != want.tag)
                    report_mismatch("served_tag", rsp_if.served_tag, want.tag);
                if (rsp_if.served_class != want.cls)
                    report_mismatch("served_class", rsp_if.served_class, want.cls);
                if (rsp_if.served_room != want.room)
                    report_mismatch("served_room", rsp_if.served_room, want.room);
            end
            if (rsp_if.status <= tlspq_pkg::ST_INVALID) answers_seen[rsp_if.status]++;
        end
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predicted = apply_request(req_if.func, req_if.priority_class, req_if.record_tag,
                                      req_if.room_number);
            typed = typed_answers.pop_front();
            awaited_answers.push_back(typed.known ? typed.ans : predicted);
        end
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one request, after a random idle stretch, and waits for it to be taken.
    task automatic send_request(logic [tlspq_pkg::FUNC_W-1:0] func,
                                logic [tlspq_pkg::CLS_W-1:0] cls,
                                logic [tlspq_pkg::TAG_W-1:0] tag,
                                logic [tlspq_pkg::ROOM_W-1:0] room,
                                bit known, t_answer ans);
        t_typed_answer entry;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        entry.known = known;
        entry.ans   = ans;
        typed_answers.push_back(entry);
        req_if.valid          <= 1'b1;
        req_if.func           <= func;
        req_if.priority_class <= cls;
        req_if.record_tag     <= tag;
        req_if.room_number    <= room;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Bursts that mostly fill, mostly drain or mix, so the rings reach full and empty.
    task automatic run_random_requests(int count);
        int                             sent;
        int                             burst_len;
        int                             serve_pct;
        logic [tlspq_pkg::CLS_W-1:0]    focus;
        logic [tlspq_pkg::CLS_W-1:0]    cls;
        int                             pick;
        t_answer                        none;
        sent = 0;
        none = '{tlspq_pkg::ST_ENQUEUED, '0, '0, '0};
        while (sent < count) begin
            burst_len = $urandom_range(40, 8);
            focus     = tlspq_pkg::CLS_W'($urandom_range(tlspq_pkg::CLS_URGENT,
                                                         tlspq_pkg::CLS_NORMAL));
            case ($urandom_range(2))
                0: serve_pct = 15;
                1: serve_pct = 85;
                default: serve_pct = 50;
            endcase
            for (int i = 0; i < burst_len && sent < count; i++) begin
                pick = $urandom_range(99);
                if (pick < 8) cls = tlspq_pkg::CLS_W'($urandom_range(CLS_HIGHEST));
                else if (pick < 60) cls = focus;
                else cls = tlspq_pkg::CLS_W'($urandom_range(tlspq_pkg::CLS_URGENT,
                                                            tlspq_pkg::CLS_NORMAL));
                if ($urandom_range(99) < serve_pct)
                    send_request(tlspq_pkg::FUNC_SERVE,
                                 tlspq_pkg::CLS_W'($urandom_range(CLS_HIGHEST)),
                                 tlspq_pkg::TAG_W'($urandom), tlspq_pkg::ROOM_W'($urandom),
                                 1'b0, none);
                else
                    send_request(tlspq_pkg::FUNC_ENQUEUE, cls, tlspq_pkg::TAG_W'($urandom),
                                 tlspq_pkg::ROOM_W'($urandom), 1'b0, none);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.func           = tlspq_pkg::FUNC_ENQUEUE;
        req_if.priority_class = CLS_NONE;
        req_if.record_tag     = '0;
        req_if.room_number    = '0;
        rsp_if.ready          = 1'b0;
        for (int k = 0; k < tlspq_pkg::CLASS_COUNT; k++) begin
            ring_head[k] = 0;
            ring_tail[k] = 0;
            ring_fill[k] = 0;
        end
        foreach (answers_seen[s]) answers_seen[s] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty serve, invalid classes, extremes, a full ring.
        send_idle_pct  = 27;
        recv_stall_pct = 48;
        foreach (plan[r]) begin
            for (int i = 0; i < plan[r].reps; i++)
                send_request(plan[r].func, plan[r].cls, plan[r].tag + tlspq_pkg::TAG_W'(i),
                             plan[r].room, plan[r].known, plan[r].ans);
        end

        // Random part, in three phases of send idling and receive stalling, the last with none.
        run_random_requests(RANDOM_PER_PHASE);
        send_idle_pct  = 48;
        recv_stall_pct = 27;
        run_random_requests(RANDOM_PER_PHASE);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_requests(RANDOM_PER_PHASE);
        req_if.valid <= 1'b0;

        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("answers: %0d stored, %0d served, %0d on empty queues, %0d on a full ring,",
                 answers_seen[tlspq_pkg::ST_ENQUEUED], answers_seen[tlspq_pkg::ST_SERVED],
                 answers_seen[tlspq_pkg::ST_EMPTY], answers_seen[tlspq_pkg::ST_FULL]);
        $display("%0d for an invalid class; %0d field mismatches",
                 answers_seen[tlspq_pkg::ST_INVALID], mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
